// File: hw/rtl/bdc_pkg.sv
// Shared types, codes and helper functions of the backlight dimming controller.
package bdc_pkg;

  // Widths of the item fields and registers
  localparam int COUNT_W  = 16;
  localparam int TICK_W   = 16;
  localparam int LEVEL_W  = 8;
  localparam int PCT_W    = 7;
  localparam int STEP_W   = 3;
  localparam int GUI_W    = 2;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int PROD_W   = 2 * PCT_W;

  localparam logic [PCT_W-1:0]   PCT_MAX   = PCT_W'(100);
  localparam logic [LEVEL_W-1:0] LEVEL_RST = LEVEL_W'(50);
  localparam logic [TICK_W-1:0]  TICKS_RST = TICK_W'(1000);

  // Reciprocal of 100 scaled by 2^19, exact for products up to 100*100
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = PROD_W + 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

  // Reciprocal of 3 scaled by 2^9, exact for 8-bit values
  localparam int DIV3_SHIFT = 9;
  localparam int DIV3_W     = LEVEL_W + 8;
  localparam logic [DIV3_W-1:0] DIV3_RECIP = DIV3_W'(171);

  // Common width for comparing an interval against the counter's top value
  localparam int LOAD_W = (COUNT_W > TICK_W) ? COUNT_W : TICK_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_ON   = 2'd2,
    CMD_OFF  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_MODE   = 2'd0,
    REG_REDUCE_TICKS = 2'd1,
    REG_OFF_TICKS    = 2'd2,
    REG_MIN_DUTY     = 2'd3
  } cfg_reg_t;

  localparam logic [GUI_W-1:0] GUI_NONE   = 2'd0;
  localparam logic [GUI_W-1:0] GUI_LOCK   = 2'd1;
  localparam logic [GUI_W-1:0] GUI_UNLOCK = 2'd2;

  localparam logic [1:0] STAGE_CODE_OFF  = 2'd0;
  localparam logic [1:0] STAGE_CODE_FULL = 2'd1;
  localparam logic [1:0] STAGE_CODE_RED  = 2'd2;

  // Backlight stage, one-hot
  typedef enum logic [2:0] {
    STG_OFF  = 3'b001,
    STG_FULL = 3'b010,
    STG_RED  = 3'b100
  } stage_t;

  // Drive state: sink settings plus the duty kept as product and floor
  typedef struct packed {
    logic [STEP_W-1:0] sink_step;
    logic              sink_on;
    logic              pwm_down;
    logic [PROD_W-1:0] prod;
    logic [PCT_W-1:0]  m;
  } drive_t;

  // Stage as the two-bit code seen on the result channel
  function automatic logic [1:0] stage_code(input stage_t s);
    logic [1:0] c;
    case (s)
      STG_OFF:  c = STAGE_CODE_OFF;
      STG_FULL: c = STAGE_CODE_FULL;
      STG_RED:  c = STAGE_CODE_RED;
      default:  c = STAGE_CODE_OFF;
    endcase
    return c;
  endfunction

  // Divide by three: multiply by the scaled reciprocal and drop the fraction
  function automatic logic [LEVEL_W-1:0] div3(input logic [LEVEL_W-1:0] x);
    logic [DIV3_W-1:0] p;
    p = DIV3_W'(x) * DIV3_RECIP;
    return LEVEL_W'(p[DIV3_W-1:DIV3_SHIFT]);
  endfunction

  // Interval load, saturated to the counter's top value
  function automatic logic [COUNT_W-1:0] load_value(input logic [TICK_W-1:0] t);
    logic [LOAD_W-1:0] top;
    top = LOAD_W'({COUNT_W{1'b1}});
    if (LOAD_W'(t) > top) begin
      return '1;
    end
    return COUNT_W'(t);
  endfunction

endpackage

// File: hw/rtl/bdc_in_if.sv
// Command item channel.
interface bdc_in_if import bdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [LEVEL_W-1:0] brightness;
  logic               unlock_gui;

  modport source (output valid, cmd, brightness, unlock_gui, input ready);
  modport sink   (input valid, cmd, brightness, unlock_gui, output ready);
endinterface

// File: hw/rtl/bdc_out_if.sv
// Result item channel.
interface bdc_out_if import bdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] sink_step;
  logic              sink_on;
  logic [PCT_W-1:0]  pwm_duty;
  logic              pwm_down;
  logic [GUI_W-1:0]  gui_request;
  logic [1:0]        stage_now;

  modport source (output valid, sink_step, sink_on, pwm_duty, pwm_down, gui_request,
                  stage_now, input ready);
  modport sink   (input valid, sink_step, sink_on, pwm_duty, pwm_down, gui_request,
                  stage_now, output ready);
endinterface

// File: hw/rtl/bdc_cfg_if.sv
// Configuration write channel.
interface bdc_cfg_if import bdc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bdc_drive.sv
// Drive update: maps a brightness value and enable onto the sink and PWM settings.
module bdc_drive import bdc_pkg::*; (
  input  logic               upd,
  input  logic [LEVEL_W-1:0] v,
  input  logic               en,
  input  logic               mode,
  input  logic [PCT_W-1:0]   min_duty,
  input  drive_t             cur,
  output drive_t             nxt,
  output logic               lock
);

  logic [PCT_W-1:0] vc;
  logic [PCT_W-1:0] m;
  logic [PCT_W-1:0] span;

  // Clamp value and floor to 100
  assign vc   = (v > LEVEL_W'(PCT_MAX)) ? PCT_MAX : v[PCT_W-1:0];
  assign m    = (min_duty > PCT_MAX) ? PCT_MAX : min_duty;
  assign span = PCT_W'(PCT_MAX - m);

  always_comb begin
    nxt  = cur;
    lock = 1'b0;
    if (upd) begin
      if (!mode) begin
        // Current sink steps of 20 percent
        if (vc < PCT_W'(20))      nxt.sink_step = STEP_W'(0);
        else if (vc < PCT_W'(40)) nxt.sink_step = STEP_W'(1);
        else if (vc < PCT_W'(60)) nxt.sink_step = STEP_W'(2);
        else if (vc < PCT_W'(80)) nxt.sink_step = STEP_W'(3);
        else                      nxt.sink_step = STEP_W'(4);
        nxt.sink_on = en;
      end else begin
        // PWM drive with the sink at its top step
        nxt.sink_step = STEP_W'(4);
        nxt.sink_on   = en;
        if (!en) begin
          nxt.pwm_down = 1'b1;
          lock         = 1'b1;
        end else begin
          nxt.prod     = PROD_W'(vc) * PROD_W'(span);
          nxt.m        = m;
          nxt.pwm_down = 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/backlight_dimming_controller_core.sv
// An accepted item passes the state registers, then the result register.
// Throughput: one item per cycle; the pipeline stalls only while a result waits.
// The state update is done at acceptance; the second stage forms the PWM duty
// with a reciprocal multiply of the stored product.
// Reset (rst_n low, synchronous): stage off, level 50, timer stopped,
// sink off, PWM down with duty 0, registers at their defaults.
module backlight_dimming_controller_core import bdc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  bdc_in_if.sink  in_ch,
  bdc_out_if.source out_ch,
  bdc_cfg_if.sink cfg_ch
);

  // Configuration registers
  logic              drive_mode_r;
  logic [TICK_W-1:0] reduce_ticks_r;
  logic [TICK_W-1:0] off_ticks_r;
  logic [PCT_W-1:0]  min_duty_r;

  // Controller state
  stage_t             stage_r, stage_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [COUNT_W-1:0] countdown_r, countdown_nxt;
  logic               counting_r, counting_nxt;
  drive_t             drive_r, drive_nxt;
  logic [GUI_W-1:0]   gui_r, gui_nxt;
  logic               s1_valid_r;

  // Result register
  logic              out_valid_r;
  logic [STEP_W-1:0] sink_step_r;
  logic              sink_on_r;
  logic [PCT_W-1:0]  pwm_duty_r, pwm_duty_nxt;
  logic              pwm_down_r;
  logic [GUI_W-1:0]  gui_req_r;
  logic [1:0]        stage_now_r;

  logic               adv;
  logic               in_acc;
  logic               upd;
  logic [LEVEL_W-1:0] upd_v;
  logic               upd_en;
  logic               lock;
  logic [RECIP_W-1:0] quo_full;
  logic [PCT_W:0]     duty_sum;

  // Pipeline moves unless a result is held
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign in_acc       = in_ch.valid && adv;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_mode_r   <= 1'b0;
      reduce_ticks_r <= TICKS_RST;
      off_ticks_r    <= TICKS_RST;
      min_duty_r     <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_DRIVE_MODE:   drive_mode_r   <= cfg_ch.data[0];
        REG_REDUCE_TICKS: reduce_ticks_r <= cfg_ch.data[TICK_W-1:0];
        REG_OFF_TICKS:    off_ticks_r    <= cfg_ch.data[TICK_W-1:0];
        REG_MIN_DUTY:     min_duty_r     <= cfg_ch.data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode: next stage, timer and drive request
  always_comb begin
    stage_nxt     = stage_r;
    level_nxt     = level_r;
    countdown_nxt = countdown_r;
    counting_nxt  = counting_r;
    upd           = 1'b0;
    upd_v         = level_r;
    upd_en        = 1'b0;
    case (cmd_t'(in_ch.cmd))
      CMD_TICK: begin
        if (counting_r) begin
          if (countdown_r <= COUNT_W'(1)) begin
            upd = 1'b1;
            if (stage_r == STG_RED) begin
              counting_nxt  = 1'b0;
              countdown_nxt = '0;
            end else begin
              stage_nxt     = STG_RED;
              upd_v         = div3(level_r);
              upd_en        = 1'b1;
              countdown_nxt = load_value(off_ticks_r);
            end
          end else begin
            countdown_nxt = COUNT_W'(countdown_r - COUNT_W'(1));
          end
        end
      end
      CMD_SET: begin
        level_nxt = in_ch.brightness;
        upd       = 1'b1;
        upd_v     = in_ch.brightness;
        case (stage_r)
          STG_FULL: upd_en = 1'b1;
          STG_RED: begin
            upd_v  = div3(in_ch.brightness);
            upd_en = 1'b1;
          end
          default: upd_en = 1'b0;
        endcase
      end
      CMD_ON: begin
        stage_nxt     = STG_FULL;
        countdown_nxt = load_value(reduce_ticks_r);
        counting_nxt  = 1'b1;
        upd           = 1'b1;
        upd_en        = 1'b1;
      end
      CMD_OFF: begin
        counting_nxt = 1'b0;
        upd          = 1'b1;
        stage_nxt    = STG_OFF;
      end
      default: ;
    endcase
  end

  bdc_drive u_drive (
    .upd      (upd),
    .v        (upd_v),
    .en       (upd_en),
    .mode     (drive_mode_r),
    .min_duty (min_duty_r),
    .cur      (drive_r),
    .nxt      (drive_nxt),
    .lock     (lock)
  );

  // GUI request of this item; unlock wins on a turn-on
  always_comb begin
    gui_nxt = lock ? GUI_LOCK : GUI_NONE;
    if (cmd_t'(in_ch.cmd) == CMD_ON && in_ch.unlock_gui) begin
      gui_nxt = GUI_UNLOCK;
    end
  end

  // State update at acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= STG_OFF;
      level_r     <= LEVEL_RST;
      countdown_r <= '0;
      counting_r  <= 1'b0;
      drive_r     <= '{sink_step: '0, sink_on: 1'b0, pwm_down: 1'b1, prod: '0, m: '0};
      gui_r       <= GUI_NONE;
      s1_valid_r  <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= in_acc;
      end
      if (in_acc) begin
        stage_r     <= stage_nxt;
        level_r     <= level_nxt;
        countdown_r <= countdown_nxt;
        counting_r  <= counting_nxt;
        drive_r     <= drive_nxt;
        gui_r       <= gui_nxt;
      end
    end
  end

  // Duty = floor + product / 100
  assign quo_full     = RECIP_W'(drive_r.prod) * RECIP_100;
  assign duty_sum     = (PCT_W+1)'(drive_r.m) + (PCT_W+1)'(quo_full[RECIP_W-1:RECIP_SHIFT]);
  assign pwm_duty_nxt = duty_sum[PCT_W-1:0];

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sink_step_r <= drive_r.sink_step;
      sink_on_r   <= drive_r.sink_on;
      pwm_duty_r  <= pwm_duty_nxt;
      pwm_down_r  <= drive_r.pwm_down;
      gui_req_r   <= gui_r;
      stage_now_r <= stage_code(stage_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sink_step   = sink_step_r;
  assign out_ch.sink_on     = sink_on_r;
  assign out_ch.pwm_duty    = pwm_duty_r;
  assign out_ch.pwm_down    = pwm_down_r;
  assign out_ch.gui_request = gui_req_r;
  assign out_ch.stage_now   = stage_now_r;

endmodule

// File: hw/rtl/bdc_checker.sv
// Port-level checks of the backlight dimming controller, bound to the top level.
module bdc_checker import bdc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STEP_W-1:0] sink_step,
  input logic              sink_on,
  input logic [PCT_W-1:0]  pwm_duty,
  input logic              pwm_down,
  input logic [GUI_W-1:0]  gui_request,
  input logic [1:0]        stage_now
);

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sink_step) && $stable(pwm_duty)
      && $stable(gui_request) && $stable(stage_now))
    else $error("result changed while stalled");

  // No result comes out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Fields stay in their legal ranges
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sink_step <= STEP_W'(4) && pwm_duty <= PCT_MAX && stage_now != 2'd3
      && gui_request != 2'd3)
    else $error("result field out of range");

  // A lock request only comes with the drive switched off
  a_lock_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && gui_request == GUI_LOCK |-> pwm_down && !sink_on && sink_step == STEP_W'(4))
    else $error("GUI lock without drive off");

  // An unlock request only comes with a turn-on to full stage
  a_unlock_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && gui_request == GUI_UNLOCK |-> sink_on && stage_now == STAGE_CODE_FULL)
    else $error("GUI unlock without turn-on");

endmodule

bind backlight_dimming_controller_core bdc_checker u_bdc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .sink_step   (out_ch.sink_step),
  .sink_on     (out_ch.sink_on),
  .pwm_duty    (out_ch.pwm_duty),
  .pwm_down    (out_ch.pwm_down),
  .gui_request (out_ch.gui_request),
  .stage_now   (out_ch.stage_now)
);

// File: tb/sv/bdc_scoreboard.sv
// Checker for the backlight dimming controller: predicts every result item and compares it.
`timescale 1ns / 1ps

module bdc_scoreboard import bdc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bdc_in_if    in_mon,
  bdc_out_if   out_mon,
  bdc_cfg_if   cfg_mon,
  output int   mismatches,
  output int   outstanding
);

  typedef enum logic [1:0] {
    LIGHT_OFF  = STAGE_CODE_OFF,
    LIGHT_FULL = STAGE_CODE_FULL,
    LIGHT_DIM  = STAGE_CODE_RED
  } light_t;

  // One predicted drive setting, as it shows on the result channel
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              sink_en;
    logic [PCT_W-1:0]  duty;
    logic              pwm_off;
    logic [GUI_W-1:0]  gui;
    logic [1:0]        light;
  } drive_rec_t;

  // Register copies
  logic              mode_pwm;
  logic [TICK_W-1:0] dim_after;
  logic [TICK_W-1:0] dark_after;
  logic [PCT_W-1:0]  duty_floor;

  // Controller state
  light_t             light;
  logic [LEVEL_W-1:0] level;
  logic [COUNT_W-1:0] ticks_left;
  logic               timer_run;

  // Drive registers
  logic [STEP_W-1:0] step_q;
  logic              sink_en_q;
  logic [PCT_W-1:0]  duty_q;
  logic              pwm_off_q;
  logic [GUI_W-1:0]  gui_q;

  drive_rec_t drive_due[$];
  int         err_count = 0;

  assign mismatches = err_count;

  // Drive update with value v and enable en
  function automatic void set_drive(input int v, input bit en);
    int vc;
    int fl;
    vc = (v > 100) ? 100 : v;
    sink_en_q = en;
    if (!mode_pwm) begin
      if (vc < 20)      step_q = 3'd0;
      else if (vc < 40) step_q = 3'd1;
      else if (vc < 60) step_q = 3'd2;
      else if (vc < 80) step_q = 3'd3;
      else              step_q = 3'd4;
    end else begin
      fl = (duty_floor > 100) ? 100 : int'(duty_floor);
      step_q = 3'd4;
      if (!en) begin
        pwm_off_q = 1'b1;
        gui_q     = GUI_LOCK;
      end else begin
        duty_q    = PCT_W'(fl + (vc * (100 - fl)) / 100);
        pwm_off_q = 1'b0;
      end
    end
  endfunction

  // Apply one command item and return the drive that follows it
  function automatic drive_rec_t advance_backlight(input cmd_t c, input logic [LEVEL_W-1:0] b,
                                                   input logic unlock);
    drive_rec_t r;
    gui_q = GUI_NONE;
    case (c)
      CMD_TICK: begin
        if (timer_run) begin
          if (ticks_left <= 1) begin
            if (light == LIGHT_DIM) begin
              set_drive(level, 1'b0);
              timer_run  = 1'b0;
              ticks_left = '0;
            end else begin
              light = LIGHT_DIM;
              set_drive(level / 3, 1'b1);
              ticks_left = dark_after;
            end
          end else begin
            ticks_left = ticks_left - 1'b1;
          end
        end
      end
      CMD_SET: begin
        level = b;
        if (light == LIGHT_FULL)     set_drive(level, 1'b1);
        else if (light == LIGHT_DIM) set_drive(level / 3, 1'b1);
        else                         set_drive(level, 1'b0);
      end
      CMD_ON: begin
        light      = LIGHT_FULL;
        ticks_left = dim_after;
        timer_run  = 1'b1;
        set_drive(level, 1'b1);
        if (unlock) gui_q = GUI_UNLOCK;
      end
      default: begin
        timer_run = 1'b0;
        set_drive(level, 1'b0);
        light = LIGHT_OFF;
      end
    endcase
    r.step    = step_q;
    r.sink_en = sink_en_q;
    r.duty    = duty_q;
    r.pwm_off = pwm_off_q;
    r.gui     = gui_q;
    r.light   = light;
    return r;
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endfunction

  // Watch the three channels at each edge
  always @(posedge clk) begin : watch
    drive_rec_t want;
    if (!rst_n) begin
      mode_pwm   = 1'b0;
      dim_after  = TICKS_RST;
      dark_after = TICKS_RST;
      duty_floor = '0;
      light      = LIGHT_OFF;
      level      = LEVEL_RST;
      ticks_left = '0;
      timer_run  = 1'b0;
      step_q     = '0;
      sink_en_q  = 1'b0;
      duty_q     = '0;
      pwm_off_q  = 1'b1;
      gui_q      = GUI_NONE;
      drive_due.delete();
    end else begin
      // result side: oldest expectation first
      if (out_mon.valid && out_mon.ready) begin
        if (drive_due.size() == 0) begin
          $display("%0t: result item with nothing expected, actual step %0d duty %0d stage %0d",
                   $time, out_mon.sink_step, out_mon.pwm_duty, out_mon.stage_now);
          err_count++;
        end else begin
          want = drive_due.pop_front();
          check_field("sink_step", want.step, out_mon.sink_step);
          check_field("sink_on", want.sink_en, out_mon.sink_on);
          check_field("pwm_duty", want.duty, out_mon.pwm_duty);
          check_field("pwm_down", want.pwm_off, out_mon.pwm_down);
          check_field("gui_request", want.gui, out_mon.gui_request);
          check_field("stage_now", want.light, out_mon.stage_now);
        end
      end
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          REG_DRIVE_MODE:   mode_pwm   = cfg_mon.data[0];
          REG_REDUCE_TICKS: dim_after  = cfg_mon.data[TICK_W-1:0];
          REG_OFF_TICKS:    dark_after = cfg_mon.data[TICK_W-1:0];
          default:          duty_floor = cfg_mon.data[PCT_W-1:0];
        endcase
      end
      // command side
      if (in_mon.valid && in_mon.ready)
        drive_due.push_back(advance_backlight(cmd_t'(in_mon.cmd), in_mon.brightness,
                                              in_mon.unlock_gui));
    end
    outstanding <= drive_due.size();
  end

endmodule

// File: tb/sv/backlight_dimming_controller_core_tb.sv
// Top of the backlight dimming controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module backlight_dimming_controller_core_tb import bdc_pkg::*; ();

  logic clk;
  logic rst_n;

  bdc_in_if  in_ch();
  bdc_out_if out_ch();
  bdc_cfg_if cfg_ch();

  int tx_idle_pct;
  int rx_stall_pct;
  bit want_hold;
  int mismatches;
  int outstanding;

  backlight_dimming_controller_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bdc_scoreboard u_scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls plus one long hold-off
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 199;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // One register write; valid stays up for a following write
  task automatic put_reg(input cfg_reg_t r, input logic [CFG_DAT_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic write_regs(input logic mode, input logic [TICK_W-1:0] dim_t,
                            input logic [TICK_W-1:0] dark_t, input logic [PCT_W-1:0] fl);
    put_reg(REG_DRIVE_MODE, CFG_DAT_W'(mode));
    put_reg(REG_REDUCE_TICKS, dim_t);
    put_reg(REG_OFF_TICKS, dark_t);
    put_reg(REG_MIN_DUTY, CFG_DAT_W'(fl));
    cfg_ch.valid <= 1'b0;
  endtask

  // One command item, with random idle cycles ahead of it
  task automatic send_item(input cmd_t c, input logic [LEVEL_W-1:0] b, input logic u);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.brightness <= b;
    in_ch.unlock_gui <= u;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly short intervals so the timer expires often, now and then an extreme
  function automatic logic [TICK_W-1:0] pick_interval();
    int r;
    r = $urandom_range(99);
    if (r < 5)       return '0;
    else if (r < 10) return '1;
    else if (r < 15) return TICK_W'($urandom);
    else             return TICK_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [PCT_W-1:0] pick_floor();
    int r;
    r = $urandom_range(99);
    if (r < 10)      return '0;
    else if (r < 20) return PCT_MAX;
    else if (r < 25) return '1;
    else             return PCT_W'($urandom_range(0, 100));
  endfunction

  task automatic random_items(input int count);
    int r;
    cmd_t c;
    logic [LEVEL_W-1:0] b;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 45)      c = CMD_TICK;
      else if (r < 65) c = CMD_SET;
      else if (r < 85) c = CMD_ON;
      else             c = CMD_OFF;
      if ($urandom_range(3) == 0) b = LEVEL_W'($urandom_range(101, 255));
      else                        b = LEVEL_W'($urandom_range(0, 100));
      send_item(c, b, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_TICK;
    in_ch.brightness <= '0;
    in_ch.unlock_gui <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_DRIVE_MODE;
    cfg_ch.data      <= '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    want_hold    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sink mode: brightness clamp, step boundaries, dim then dark, stopped timer
    write_regs(1'b0, 16'd2, 16'd1, 7'd0);
    send_item(CMD_SET, 8'd0, 1'b0);
    send_item(CMD_SET, 8'd255, 1'b0);
    send_item(CMD_SET, 8'd19, 1'b0);
    send_item(CMD_SET, 8'd20, 1'b0);
    send_item(CMD_SET, 8'd39, 1'b0);
    send_item(CMD_SET, 8'd40, 1'b0);
    send_item(CMD_SET, 8'd59, 1'b0);
    send_item(CMD_SET, 8'd60, 1'b0);
    send_item(CMD_SET, 8'd79, 1'b0);
    send_item(CMD_SET, 8'd80, 1'b0);
    send_item(CMD_ON, 8'd0, 1'b1);
    send_item(CMD_TICK, 8'd0, 1'b0);
    send_item(CMD_TICK, 8'd0, 1'b0);
    send_item(CMD_SET, 8'd100, 1'b0);
    send_item(CMD_TICK, 8'd0, 1'b0);
    send_item(CMD_SET, 8'd90, 1'b0);
    send_item(CMD_TICK, 8'd0, 1'b0);
    send_item(CMD_OFF, 8'd0, 1'b0);
    drain();

    // PWM mode: zero interval acts as one, oversized floor saturates
    write_regs(1'b1, 16'd0, 16'hFFFF, 7'h7F);
    send_item(CMD_SET, 8'd255, 1'b0);
    send_item(CMD_ON, 8'd0, 1'b0);
    send_item(CMD_TICK, 8'd0, 1'b0);
    send_item(CMD_SET, 8'd7, 1'b0);
    send_item(CMD_OFF, 8'd0, 1'b0);
    drain();

    write_regs(1'b1, 16'hFFFF, 16'd1, PCT_MAX);
    send_item(CMD_ON, 8'd255, 1'b1);
    send_item(CMD_SET, 8'd0, 1'b0);
    drain();

    // Random part in three idling groups, three settings each
    for (int g = 0; g < 3; g++) begin
      case (g)
        0: begin tx_idle_pct = 16; rx_stall_pct = 83; end
        1: begin tx_idle_pct = 83; rx_stall_pct = 16; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      for (int k = 0; k < 3; k++) begin
        write_regs(1'((g + k) % 2), pick_interval(), pick_interval(), pick_floor());
        if (g == 0 && k == 0) want_hold = 1'b1;
        random_items(211);
        drain();
      end
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
